// ----- design/bfpa_pkg.sv -----
// Shared constants for the bin frequency to phase accumulator.
// Used by the core and by its port checker; depends on nothing else.
package bfpa_pkg;

	// Number of phase accumulators and the widths that follow from it.
	localparam int MAX_BINS = 1024;
	localparam int BIN_W    = $clog2(MAX_BINS);
	localparam int FILL_W   = BIN_W + 1;

	// Field and register widths.
	localparam int MAG_W     = 24;
	localparam int FREQ_W    = 32;
	localparam int PHASE_W   = 32;
	localparam int OUT_PH_W  = 16;
	localparam int CNT_REG_W = 11;
	localparam int SPC_W     = 31;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_SPACING  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_PER_HZ = 2'd2;

	// Reset value of the bins-per-frame register.
	localparam logic [CNT_REG_W-1:0] BIN_COUNT_RST = CNT_REG_W'(MAX_BINS);

endpackage

// ----- design/bin_frequency_to_phase_accumulator_core.sv -----
// Phase vocoder phase accumulation core: one spectral bin per request.
// Depends on bfpa_pkg and instantiates bfpa_ram for the per-bin phases.
//
// Usage:
// Each input request carries a bin magnitude and its instantaneous frequency.
// A bin counter names the bin and wraps after bin_count bins (2 to 1024). The
// core subtracts the bin centre frequency, scales the offset by phase_per_hz,
// adds it to that bin's stored phase and returns the top 16 bits of the new
// phase with the magnitude, the bin index and a frame end flag.
// Input and output channels use valid and stall; a request moves when valid
// is high and stall is low. The configuration channel uses valid and ready,
// is always ready. The user must write it only while the core is idle; the
// core does not enforce this. An accepted request reaches the output register
// through four register stages: centre frequency multiply, offset subtract,
// increment multiply with phase memory read, then accumulate with memory
// write-back. The core takes one request in every cycle while the output is
// not stalled. A stalled output holds its result; each stage moves while the
// next has room; input stalls only while all four are full and output stalls.
// Reset clears all phases (a fill count marks the bins written so far), the
// bin counter, and the registers to bin_count 1024 and zero coefficients.
module bin_frequency_to_phase_accumulator_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration write channel.
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bfpa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bfpa_pkg::CFG_DAT_W-1:0]       cfg_data,
	// Input bin channel.
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [bfpa_pkg::MAG_W-1:0]           magnitude_in,
	input  logic signed [bfpa_pkg::FREQ_W-1:0]   frequency_in,
	// Output result channel.
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [bfpa_pkg::MAG_W-1:0]           magnitude_out,
	output logic signed [bfpa_pkg::OUT_PH_W-1:0] phase_out,
	output logic [bfpa_pkg::BIN_W-1:0]           bin_index,
	output logic                                 frame_end
);

	import bfpa_pkg::*;

	localparam int PROD1_W = BIN_W + SPC_W;

	// Configuration registers.
	logic [CNT_REG_W-1:0] bin_count_q;
	logic [SPC_W-1:0]     bin_spacing_q;
	logic [PHASE_W-1:0]   phase_per_hz_q;

	// Bin counter and count of bins written since reset.
	logic [BIN_W-1:0]  bin_counter_q;
	logic [FILL_W-1:0] fill_q;

	// Stage 1: centre frequency product.
	logic               valid_s1;
	logic [MAG_W-1:0]   mag_s1;
	logic [FREQ_W-1:0]  freq_s1;
	logic [BIN_W-1:0]   idx_s1;
	logic               end_s1;
	logic [PHASE_W-1:0] centre_s1;

	// Stage 2: frequency offset.
	logic               valid_s2;
	logic [MAG_W-1:0]   mag_s2;
	logic [BIN_W-1:0]   idx_s2;
	logic               end_s2;
	logic [PHASE_W-1:0] offset_s2;

	// Stage 3: phase increment and stored phase.
	logic               valid_s3;
	logic [MAG_W-1:0]   mag_s3;
	logic [BIN_W-1:0]   idx_s3;
	logic               end_s3;
	logic [PHASE_W-1:0] inc_s3;
	logic               written_s3;
	logic [PHASE_W-1:0] ram_rdata;

	// Stage 4: output register.
	logic               valid_s4;
	logic [MAG_W-1:0]   mag_s4;
	logic [BIN_W-1:0]   idx_s4;
	logic               end_s4;
	logic [PHASE_W-1:0] phase_s4;

	// Stage load enables and datapath terms.
	logic                 load_s1;
	logic                 load_s2;
	logic                 load_s3;
	logic                 load_s4;
	logic                 in_accept;
	logic [BIN_W-1:0]     last_bin;
	logic                 is_last;
	logic [PROD1_W-1:0]   centre_full;
	logic [2*PHASE_W-1:0] inc_full;
	logic [PHASE_W-1:0]   old_phase;
	logic [PHASE_W-1:0]   new_phase;

	// Configuration writes; the channel never pushes back.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q    <= BIN_COUNT_RST;
			bin_spacing_q  <= '0;
			phase_per_hz_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BIN_COUNT:    bin_count_q    <= cfg_data[CNT_REG_W-1:0];
				REG_BIN_SPACING:  bin_spacing_q  <= cfg_data[SPC_W-1:0];
				REG_PHASE_PER_HZ: phase_per_hz_q <= cfg_data[PHASE_W-1:0];
				default:          ;
			endcase
		end
	end

	// A stage loads when it is empty or the stage after it moves on.
	assign load_s4   = !valid_s4 || !out_stall;
	assign load_s3   = !valid_s3 || load_s4;
	assign load_s2   = !valid_s2 || load_s3;
	assign load_s1   = !valid_s1 || load_s2;
	assign in_stall  = !load_s1;
	assign in_accept = in_valid && load_s1;

	// Last bin of the frame, with bin_count clamped to the supported range.
	always_comb begin
		if (bin_count_q < CNT_REG_W'(2)) begin
			last_bin = BIN_W'(1);
		end else if (bin_count_q > CNT_REG_W'(MAX_BINS)) begin
			last_bin = BIN_W'(MAX_BINS - 1);
		end else begin
			last_bin = BIN_W'(bin_count_q - CNT_REG_W'(1));
		end
	end

	assign is_last = (bin_counter_q >= last_bin);

	// Bin counter advances on every accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_counter_q <= '0;
		end else if (in_accept) begin
			bin_counter_q <= is_last ? '0 : bin_counter_q + BIN_W'(1);
		end
	end

	// Stage 1: bin index times spacing; only the low 32 bits matter.
	assign centre_full = PROD1_W'(bin_counter_q) * PROD1_W'(bin_spacing_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			mag_s1    <= magnitude_in;
			freq_s1   <= frequency_in;
			idx_s1    <= bin_counter_q;
			end_s1    <= is_last;
			centre_s1 <= centre_full[PHASE_W-1:0];
		end
	end

	// Stage 2: offset from the bin centre, modulo 2^32.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			mag_s2    <= mag_s1;
			idx_s2    <= idx_s1;
			end_s2    <= end_s1;
			offset_s2 <= freq_s1 - centre_s1;
		end
	end

	// Stage 3: low half of offset times phase_per_hz. The phase memory is read
	// on the same edge. The request ahead writes on that edge too, but two
	// consecutive requests never share a bin, so no forwarding is needed.
	assign inc_full = (2*PHASE_W)'(offset_s2) * (2*PHASE_W)'(phase_per_hz_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (load_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s3 && valid_s2) begin
			mag_s3     <= mag_s2;
			idx_s3     <= idx_s2;
			end_s3     <= end_s2;
			inc_s3     <= inc_full[PHASE_W-1:0];
			written_s3 <= ({1'b0, idx_s2} < fill_q);
		end
	end

	// Bins are visited in order from zero, so those written since reset are
	// exactly the ones below the fill count; the rest still read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (load_s4 && valid_s3 && ({1'b0, idx_s3} == fill_q)) begin
			fill_q <= fill_q + FILL_W'(1);
		end
	end

	assign old_phase = written_s3 ? ram_rdata : '0;
	assign new_phase = old_phase + inc_s3;

	bfpa_ram #(
		.WIDTH (PHASE_W),
		.DEPTH (MAX_BINS)
	) u_phase_ram (
		.clk   (clk),
		.we    (load_s4 && valid_s3),
		.waddr (idx_s3),
		.wdata (new_phase),
		.re    (load_s3 && valid_s2),
		.raddr (idx_s2),
		.rdata (ram_rdata)
	);

	// Stage 4: accumulated phase into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (load_s4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s4 && valid_s3) begin
			mag_s4   <= mag_s3;
			idx_s4   <= idx_s3;
			end_s4   <= end_s3;
			phase_s4 <= new_phase;
		end
	end

	// Output ports.
	assign out_valid     = valid_s4;
	assign magnitude_out = mag_s4;
	assign phase_out     = phase_s4[PHASE_W-1 -: OUT_PH_W];
	assign bin_index     = idx_s4;
	assign frame_end     = end_s4;

endmodule

// ----- design/bfpa_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
module bfpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the output holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/bfpa_checker.sv -----
// Port-level checker for the phase accumulator core, with its bind statement.
// Depends on bfpa_pkg; sees only the top level's ports.
module bfpa_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic [bfpa_pkg::MAG_W-1:0]           magnitude_out,
	input logic signed [bfpa_pkg::OUT_PH_W-1:0] phase_out,
	input logic [bfpa_pkg::BIN_W-1:0]           bin_index,
	input logic                                 frame_end
);

	import bfpa_pkg::*;

	logic             out_accept;
	logic [BIN_W-1:0] expect_idx_q;

	assign out_accept = out_valid && !out_stall;

	// Bin index that the next delivered result must carry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_idx_q <= '0;
		end else if (out_accept) begin
			expect_idx_q <= frame_end ? '0 : bin_index + BIN_W'(1);
		end
	end

	// A stalled result stays on the port unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(phase_out)
			&& $stable(bin_index) && $stable(frame_end) && $stable(magnitude_out))
		else $error("stalled result changed or dropped");

	// Results walk the bins in order and restart after a frame end.
	a_bin_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_accept |-> bin_index == expect_idx_q)
		else $error("bin index out of sequence");

	// The highest bin always closes a frame.
	a_top_bin_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bin_index == BIN_W'(MAX_BINS - 1) |-> frame_end)
		else $error("highest bin without frame end");

	// A frame has at least two bins, so bin zero never closes one.
	a_bin0_no_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bin_index == '0 |-> !frame_end)
		else $error("frame end on bin zero");

endmodule

bind bin_frequency_to_phase_accumulator_core bfpa_checker u_bfpa_checker (.*);

// ----- test/bin_frequency_to_phase_accumulator_core_tb.sv -----
// Testbench for the bin frequency to phase accumulator core: directed and random bins,
// each result checked against a phase tracker that models the per-bin accumulation.
// Depends on bfpa_pkg and bin_frequency_to_phase_accumulator_core.
`timescale 1ns / 100ps

module bin_frequency_to_phase_accumulator_core_tb;
	import bfpa_pkg::*;

	// Index with no register behind it; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

	// One result as the core should return it.
	typedef struct packed {
		logic [MAG_W-1:0]           mag;
		logic signed [OUT_PH_W-1:0] phase;
		logic [BIN_W-1:0]           bin;
		logic                       last;
	} bin_result_t;

	// Tracks the per-bin phases and the bin counter, and holds the results still owed.
	class phase_tracker;
		bit [PHASE_W-1:0]   phase_acc [MAX_BINS];
		bit [BIN_W-1:0]     bin_ctr;
		bit [CNT_REG_W-1:0] bins_per_frame;
		bit [SPC_W-1:0]     spacing;
		bit [31:0]          turns_per_hz;
		bin_result_t        owed_q [$];
		int                 failures;

		function new();
			foreach (phase_acc[i])
				phase_acc[i] = '0;
			bin_ctr = '0;
			bins_per_frame = BIN_COUNT_RST;
			spacing = '0;
			turns_per_hz = '0;
			failures = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				REG_BIN_COUNT:    bins_per_frame = data[CNT_REG_W-1:0];
				REG_BIN_SPACING:  spacing = data[SPC_W-1:0];
				REG_PHASE_PER_HZ: turns_per_hz = data;
				default: ;
			endcase
		endfunction

		// Advances the model by one accepted request and queues its result.
		function void note_bin(logic [MAG_W-1:0] mag, logic [FREQ_W-1:0] freq);
			bit [CNT_REG_W-1:0] eff;
			bit [CNT_REG_W-1:0] last_bin;
			bit [63:0]          offset;
			bit [63:0]          prod;
			bit [PHASE_W-1:0]   acc;
			bin_result_t        res;
			eff = bins_per_frame;
			if (eff < CNT_REG_W'(2))
				eff = CNT_REG_W'(2);
			if (eff > CNT_REG_W'(MAX_BINS))
				eff = CNT_REG_W'(MAX_BINS);
			last_bin = eff - CNT_REG_W'(1);
			// Offset from the bin centre, exact in 64 bits; only the low word counts.
			offset = {{32{freq[31]}}, freq} - 64'(bin_ctr) * 64'(spacing);
			prod = offset * {32'b0, turns_per_hz};
			acc = phase_acc[bin_ctr] + prod[31:0];
			phase_acc[bin_ctr] = acc;
			res.mag = mag;
			res.phase = acc[PHASE_W-1 -: OUT_PH_W];
			res.bin = bin_ctr;
			res.last = ({1'b0, bin_ctr} >= last_bin);
			bin_ctr = res.last ? '0 : bin_ctr + 1'b1;
			owed_q.push_back(res);
		endfunction

		function void check_bin(bin_result_t got);
			bin_result_t want;
			if (owed_q.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result: mag %h phase %0d bin %0d end %b",
						got.mag, got.phase, got.bin, got.last);
				return;
			end
			want = owed_q.pop_front();
			if (got.mag !== want.mag || got.phase !== want.phase ||
				got.bin !== want.bin || got.last !== want.last) begin
				failures++;
				if (failures <= 10) begin
					$write("mismatch: expected mag %h phase %0d bin %0d end %b, ",
						want.mag, want.phase, want.bin, want.last);
					$display("got mag %h phase %0d bin %0d end %b",
						got.mag, got.phase, got.bin, got.last);
				end
			end
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DAT_W-1:0]       cfg_data;
	logic                       in_valid;
	logic                       in_stall;
	logic [MAG_W-1:0]           magnitude_in;
	logic signed [FREQ_W-1:0]   frequency_in;
	logic                       out_valid;
	logic                       out_stall;
	logic [MAG_W-1:0]           magnitude_out;
	logic signed [OUT_PH_W-1:0] phase_out;
	logic [BIN_W-1:0]           bin_index;
	logic                       frame_end;

	phase_tracker tracker = new();
	int in_idle_pct = 0;
	int out_stall_pct = 0;
	int hold_left = 0;
	int sent_total = 0;

	bin_frequency_to_phase_accumulator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.magnitude_in(magnitude_in),
		.frequency_in(frequency_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.magnitude_out(magnitude_out),
		.phase_out(phase_out),
		.bin_index(bin_index),
		.frame_end(frame_end)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Result side: check each accepted result, then choose the next stall.
	initial begin
		bin_result_t got;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got.mag = magnitude_out;
				got.phase = phase_out;
				got.bin = bin_index;
				got.last = frame_end;
				tracker.check_bin(got);
			end
			// A long hold-off lets the pipeline fill and push back on the input.
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < out_stall_pct);
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tracker.set_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Offers one bin request after an optional idle gap and waits until it is taken.
	task automatic send_bin(input logic [MAG_W-1:0] mag, input logic [FREQ_W-1:0] freq);
		int gap;
		gap = 0;
		while ($urandom_range(99) < in_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		magnitude_in <= mag;
		frequency_in <= freq;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.note_bin(mag, freq);
	endtask

	// Stops offering and waits until every owed result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [FREQ_W-1:0] pick_frequency();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2, 3: return $urandom_range(2000) - 32'd1000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [MAG_W-1:0] pick_magnitude();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return MAG_W'($urandom);
		endcase
	endfunction

	// Writes a fresh setting; the full frame size is forced when asked for.
	task automatic pick_config(input bit full_frame);
		logic [CFG_DAT_W-1:0] count;
		case ($urandom_range(5))
			0: count = 32'd0;
			1: count = 32'd1;
			2: count = 32'd2;
			3: count = $urandom_range(3, 16);
			4: count = $urandom_range(17, 1023);
			default: count = $urandom_range(1025, 2047);
		endcase
		if (full_frame)
			count = MAX_BINS;
		else if ($urandom_range(1))
			count = count | ($urandom & 32'hFFFF_F800);
		write_reg(REG_BIN_COUNT, count);
		case ($urandom_range(3))
			0: write_reg(REG_BIN_SPACING, 32'd0);
			1: write_reg(REG_BIN_SPACING, 32'hFFFF_FFFF);
			2: write_reg(REG_BIN_SPACING, $urandom_range(1, 1 << 20));
			default: write_reg(REG_BIN_SPACING, $urandom);
		endcase
		case ($urandom_range(3))
			0: write_reg(REG_PHASE_PER_HZ, 32'd0);
			1: write_reg(REG_PHASE_PER_HZ, 32'hFFFF_FFFF);
			2: write_reg(REG_PHASE_PER_HZ, $urandom_range(1, 1 << 16));
			default: write_reg(REG_PHASE_PER_HZ, $urandom);
		endcase
		if ($urandom_range(3) == 0)
			write_reg(REG_NONE, $urandom);
	endtask

	// Random bins; the idling pattern rotates every 64 requests.
	task automatic run_bins(input int count);
		int mode;
		for (int i = 0; i < count; i++) begin
			mode = (sent_total / 64) % 4;
			case (mode)
				0: begin in_idle_pct = 0; out_stall_pct = 0; end
				1: begin in_idle_pct = 80; out_stall_pct = 0; end
				2: begin in_idle_pct = 0; out_stall_pct = 80; end
				default: begin in_idle_pct = 26; out_stall_pct = 26; end
			endcase
			if (sent_total % 256 == 16)
				hold_left = 200;
			send_bin(pick_magnitude(), pick_frequency());
			sent_total++;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		magnitude_in <= '0;
		frequency_in <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: zero coefficients leave every phase at zero.
		send_bin(24'h000000, 32'h0000_0000);
		send_bin(24'hFFFFFF, 32'h7FFF_FFFF);
		drain();

		// Largest coefficients with frequency extremes over a short frame.
		write_reg(REG_BIN_COUNT, 32'd4);
		write_reg(REG_BIN_SPACING, 32'h7FFF_FFFF);
		write_reg(REG_PHASE_PER_HZ, 32'hFFFF_FFFF);
		write_reg(REG_NONE, 32'hDEAD_BEEF);
		send_bin(24'h800000, 32'h8000_0000);
		send_bin(24'h000001, 32'h7FFF_FFFF);
		send_bin(24'hFFFFFF, 32'h0000_0000);
		send_bin(24'h000000, 32'hFFFF_FFFF);
		send_bin(24'h555555, 32'h0000_0001);
		send_bin(24'hAAAAAA, 32'h5555_5555);
		send_bin(24'h123456, 32'hAAAA_AAAA);
		send_bin(24'hFEDCBA, 32'h8000_0000);
		drain();

		// A frame size of zero behaves as two.
		write_reg(REG_BIN_COUNT, 32'd0);
		write_reg(REG_BIN_SPACING, 32'd0);
		write_reg(REG_PHASE_PER_HZ, 32'h0001_0000);
		send_bin(24'h000010, 32'h0000_0001);
		send_bin(24'h000020, 32'hFFFF_FFFF);
		send_bin(24'h000030, 32'h0000_7FFF);
		drain();

		// A frame size of one, with junk above the register width.
		write_reg(REG_BIN_COUNT, 32'hFFFF_F801);
		write_reg(REG_BIN_SPACING, 32'hFFFF_FFFF);
		send_bin(24'h0F0F0F, 32'h1234_5678);
		send_bin(24'hF0F0F0, 32'h8765_4321);
		drain();

		// Frame size above the maximum clamps to the maximum.
		write_reg(REG_BIN_COUNT, 32'd2047);
		write_reg(REG_PHASE_PER_HZ, 32'h8000_0000);
		send_bin(24'h000001, 32'h0000_0003);
		send_bin(24'h000002, 32'hFFFF_FFFD);
		send_bin(24'h000003, 32'h4000_0000);
		drain();

		// Frame shortened below the current bin: the next request closes the frame.
		write_reg(REG_BIN_COUNT, 32'd2);
		send_bin(24'h00ABCD, 32'h0000_0100);
		send_bin(24'h00DCBA, 32'hFFFF_FF00);
		drain();

		// Random phases; one runs a full frame so the bin index covers its whole range.
		for (int k = 0; k < 14; k++) begin
			pick_config(k == 3);
			run_bins((k == 3) ? 1030 : 64);
			drain();
		end

		repeat (12) @(posedge clk);
		if (tracker.failures == 0 && tracker.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
